// ===== rtl/core/double_ended_priority_queue_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended priority queue unit
// Property forms used by the unit's controller, depq_ctrl.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DEPQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DEPQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/depq_pkg.sv =====
// ----------------------------------------------------------------------------
// depq_pkg
// Types, codes and the heap ordering function shared by the queue modules.
// ----------------------------------------------------------------------------
package depq_pkg;

   localparam int OP_W    = 3;
   localparam int ID_W    = 31;
   localparam int VAL_W   = 32;
   localparam int ST_W    = 3;
   localparam int CNT_O_W = 11;

   localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
   localparam logic [OP_W-1:0] OP_POP_MAX = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_MIN = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE  = 3'd3;
   localparam logic [OP_W-1:0] OP_CHANGE  = 3'd4;

   localparam logic [ST_W-1:0] ST_OK        = 3'd0;
   localparam logic [ST_W-1:0] ST_FULL      = 3'd1;
   localparam logic [ST_W-1:0] ST_EMPTY     = 3'd2;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd4;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_SCAN_RD,
      CMD_SCAN_NEXT,
      CMD_SCAN_HIT,
      CMD_FAIL,
      CMD_INS_WRITE,
      CMD_INS_MIN,
      CMD_INC,
      CMD_POP_RD,
      CMD_POP_SLOT,
      CMD_ENT_TAKE,
      CMD_POS_RD,
      CMD_TAKE_POS,
      CMD_MOVE_LAST,
      CMD_SU_RD_ORD,
      CMD_SU_RD_KP,
      CMD_SU_SWAP1,
      CMD_SU_SWAP2,
      CMD_SD_RD_ORD,
      CMD_SD_RD_KP,
      CMD_SD_PICK,
      CMD_SD_SWAP1,
      CMD_SD_SWAP2,
      CMD_NEXT_HEAP,
      CMD_DEC,
      CMD_CP_RD,
      CMD_CP_WR,
      CMD_PUBLISH
   } dp_cmd_type;

   typedef struct packed {
      dp_cmd_type      op;
      logic [ST_W-1:0] code;
   } dp_ctl_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic scan_end;
      logic key_hit;
      logic full;
      logic empty;
      logic k_zero;
      logic pos_last;
      logic first_ab;
      logic sd_end;
      logic first_ca;
      logic slot_last;
      logic heap_min;
   } dp_stat_type;

   // True when entry a sorts ahead of entry b in the selected heap.
   function automatic logic comes_first(input logic min_mode,
                                        input logic signed [VAL_W-1:0] pa,
                                        input logic [ID_W-1:0] ka,
                                        input logic signed [VAL_W-1:0] pb,
                                        input logic [ID_W-1:0] kb);
      logic res;
      if (!min_mode) begin
         res = (pa > pb) || ((pa == pb) && (ka < kb));
      end else begin
         res = (pa < pb) || ((pa == pb) && (ka > kb));
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/double_ended_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// double_ended_priority_queue_unit
// Min/max priority queue of (id, value) entries held in twin binary heaps.
// ----------------------------------------------------------------------------
// One request at a time is processed. An insert, delete or change first
// searches the held ids, one held entry at a time. Each heap repair then
// works level by level, climbing or descending, over both heaps, plus a
// setup per heap, the slot compaction after a removal and the response
// transfer. A pop skips the search. The search and the single-ported sift
// sequencer bound the worst case. A result waiting in the output register
// does not block the next request.
module double_ended_priority_queue_unit #(
   parameter int CAPACITY = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // key_id[30:0], new_value[62:31], zero
   input  logic [2:0]  req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // out_id[30:0], out_value[62:31], entry_count[73:63]
   output logic [2:0]  rsp_tuser    // status
);
   import depq_pkg::*;

   dp_ctl_type              ctl;
   dp_stat_type             stat;
   logic [ST_W-1:0]         out_status;
   logic [ID_W-1:0]         out_id;
   logic signed [VAL_W-1:0] out_value;
   logic [CNT_O_W-1:0]      out_count;

   depq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl),
      .stat       (stat)
   );

   depq_dpath #(.CAPACITY(CAPACITY)) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .stat       (stat),
      .req_op     (req_tuser),
      .req_id     (req_tdata[30:0]),
      .req_val    (req_tdata[62:31]),
      .out_status (out_status),
      .out_id     (out_id),
      .out_value  (out_value),
      .out_count  (out_count)
   );

   assign rsp_tdata = {6'b0, out_count, out_value, out_id};
   assign rsp_tuser = out_status;

endmodule

// ===== rtl/core/depq_dpath.sv =====
// ----------------------------------------------------------------------------
// depq_dpath
// Entry storage, both heaps and the working registers, driven one command
// per cycle by the controller.
// ----------------------------------------------------------------------------
module depq_dpath #(
   parameter int CAPACITY = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  depq_pkg::dp_ctl_type           ctl,
   output depq_pkg::dp_stat_type          stat,
   input  logic [depq_pkg::OP_W-1:0]      req_op,
   input  logic [depq_pkg::ID_W-1:0]      req_id,
   input  logic signed [depq_pkg::VAL_W-1:0] req_val,
   output logic [depq_pkg::ST_W-1:0]      out_status,
   output logic [depq_pkg::ID_W-1:0]      out_id,
   output logic signed [depq_pkg::VAL_W-1:0] out_value,
   output logic [depq_pkg::CNT_O_W-1:0]   out_count
);
   import depq_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   // Slots 0 .. count-1 are always the held entries.
   logic [ID_W-1:0]         key_mem  [CAPACITY];
   logic signed [VAL_W-1:0] prio_mem [CAPACITY];
   logic [IW-1:0]           ord_max_mem [CAPACITY];
   logic [IW-1:0]           ord_min_mem [CAPACITY];
   logic [IW-1:0]           pos_max_mem [CAPACITY];
   logic [IW-1:0]           pos_min_mem [CAPACITY];

   logic [ID_W-1:0]         key_qa_ff, key_qb_ff;
   logic signed [VAL_W-1:0] prio_qa_ff, prio_qb_ff;
   logic [IW-1:0]           omax_qa_ff, omax_qb_ff, omin_qa_ff, omin_qb_ff;
   logic [IW-1:0]           pmax_q_ff, pmin_q_ff;

   logic [IW-1:0] kp_ra, kp_rb, kp_wa, ord_ra, ord_rb, ord_wa_max, ord_wa_min, ord_wd;
   logic [IW-1:0] pos_ra, pos_wa, pos_wd_max, pos_wd_min;
   logic          key_we, prio_we, ord_we_max, ord_we_min, pos_we_max, pos_we_min;
   logic [ID_W-1:0]         key_wd;
   logic signed [VAL_W-1:0] prio_wd;

   logic [OP_W-1:0]         op_ff, op_in;
   logic [ID_W-1:0]         id_ff, id_in, rid_ff, rid_in, ck_ff, ck_in;
   logic signed [VAL_W-1:0] val_ff, val_in, rval_ff, rval_in, cp_ff, cp_in;
   logic [ST_W-1:0]         st_ff, st_in;
   logic [CW-1:0]           cnt_ff, cnt_in, idx_ff, idx_in, nlim_ff, nlim_in;
   logic [IW-1:0]           slot_ff, slot_in, k_ff, k_in, c_ff, c_in;
   logic [IW-1:0]           sa_ff, sa_in, sb_ff, sb_in;
   logic                    hsel_ff, hsel_in;
   logic [ST_W-1:0]         ost_ff, ost_in;
   logic [ID_W-1:0]         oid_ff, oid_in;
   logic signed [VAL_W-1:0] oval_ff, oval_in;
   logic [CNT_O_W-1:0]      ocnt_ff, ocnt_in;

   logic [IW-1:0] oq_a, oq_b, pos_q, par, pop_slot;
   logic [IW+1:0] cpos, cpos1, nlim_x;
   logic [CW-1:0] cnt_m1;
   logic          pick_b;

   assign oq_a     = hsel_ff ? omin_qa_ff : omax_qa_ff;
   assign oq_b     = hsel_ff ? omin_qb_ff : omax_qb_ff;
   assign pos_q    = hsel_ff ? pmin_q_ff : pmax_q_ff;
   assign par      = IW'((k_ff - 1'b1) >> 1);
   assign cpos     = {1'b0, k_ff, 1'b1};
   assign cpos1    = cpos + 1'b1;
   assign nlim_x   = (IW+2)'(nlim_ff);
   assign cnt_m1   = cnt_ff - 1'b1;
   assign pop_slot = (op_ff == OP_POP_MIN) ? omin_qa_ff : omax_qa_ff;
   assign pick_b   = (cpos1 < nlim_x) &&
                     comes_first(hsel_ff, prio_qb_ff, key_qb_ff, prio_qa_ff, key_qa_ff);

   always_comb begin
      stat.op        = op_ff;
      stat.scan_end  = (idx_ff == cnt_ff);
      stat.key_hit   = (key_qa_ff == id_ff);
      stat.full      = (cnt_ff == CW'(CAPACITY));
      stat.empty     = (cnt_ff == '0);
      stat.k_zero    = (k_ff == '0);
      stat.pos_last  = (CW'(pos_q) == cnt_m1);
      stat.first_ab  = comes_first(hsel_ff, prio_qa_ff, key_qa_ff, prio_qb_ff, key_qb_ff);
      stat.sd_end    = (cpos >= nlim_x);
      stat.first_ca  = comes_first(hsel_ff, cp_ff, ck_ff, prio_qa_ff, key_qa_ff);
      stat.slot_last = (CW'(slot_ff) == cnt_ff);
      stat.heap_min  = hsel_ff;
   end

   always_comb begin
      kp_ra = '0;  kp_rb = '0;  kp_wa = '0;
      ord_ra = '0; ord_rb = '0; ord_wa_max = '0; ord_wa_min = '0; ord_wd = '0;
      pos_ra = '0; pos_wa = '0; pos_wd_max = '0; pos_wd_min = '0;
      key_we = 1'b0; prio_we = 1'b0;
      ord_we_max = 1'b0; ord_we_min = 1'b0; pos_we_max = 1'b0; pos_we_min = 1'b0;
      key_wd = '0; prio_wd = '0;
      op_in = op_ff; id_in = id_ff; val_in = val_ff; rid_in = rid_ff; rval_in = rval_ff;
      ck_in = ck_ff; cp_in = cp_ff; st_in = st_ff; cnt_in = cnt_ff; idx_in = idx_ff;
      nlim_in = nlim_ff; slot_in = slot_ff; k_in = k_ff; c_in = c_ff;
      sa_in = sa_ff; sb_in = sb_ff; hsel_in = hsel_ff;
      ost_in = ost_ff; oid_in = oid_ff; oval_in = oval_ff; ocnt_in = ocnt_ff;
      case (ctl.op)
         CMD_LOAD: begin
            op_in = req_op; id_in = req_id; val_in = req_val;
            idx_in = '0; st_in = ST_OK; rid_in = '0; rval_in = '0; hsel_in = 1'b0;
         end
         CMD_SCAN_RD: kp_ra = IW'(idx_ff);
         CMD_SCAN_NEXT: idx_in = idx_ff + 1'b1;
         CMD_SCAN_HIT: begin
            slot_in = IW'(idx_ff);
            rid_in = key_qa_ff; rval_in = prio_qa_ff;
            if (op_ff == OP_CHANGE) begin
               prio_we = 1'b1; kp_wa = IW'(idx_ff); prio_wd = val_ff;
            end
         end
         CMD_FAIL: st_in = ctl.code;
         CMD_INS_WRITE: begin
            key_we = 1'b1; prio_we = 1'b1; kp_wa = IW'(cnt_ff);
            key_wd = id_ff; prio_wd = val_ff;
            ord_we_max = 1'b1; ord_we_min = 1'b1;
            ord_wa_max = IW'(cnt_ff); ord_wa_min = IW'(cnt_ff); ord_wd = IW'(cnt_ff);
            pos_we_max = 1'b1; pos_we_min = 1'b1; pos_wa = IW'(cnt_ff);
            pos_wd_max = IW'(cnt_ff); pos_wd_min = IW'(cnt_ff);
            k_in = IW'(cnt_ff); hsel_in = 1'b0; rid_in = id_ff; rval_in = val_ff;
         end
         CMD_INS_MIN: begin
            hsel_in = 1'b1; k_in = IW'(cnt_ff);
         end
         CMD_INC: cnt_in = cnt_ff + 1'b1;
         CMD_POP_RD: ord_ra = '0;
         CMD_POP_SLOT: begin
            slot_in = pop_slot; kp_ra = pop_slot;
         end
         CMD_ENT_TAKE: begin
            rid_in = key_qa_ff; rval_in = prio_qa_ff;
         end
         CMD_POS_RD: pos_ra = slot_ff;
         CMD_TAKE_POS: begin
            k_in = pos_q;
            nlim_in = (op_ff == OP_CHANGE) ? cnt_ff : cnt_m1;
            ord_ra = IW'(cnt_m1);
         end
         CMD_MOVE_LAST: begin
            ord_we_max = !hsel_ff; ord_we_min = hsel_ff;
            ord_wa_max = k_ff; ord_wa_min = k_ff; ord_wd = oq_a;
            pos_we_max = !hsel_ff; pos_we_min = hsel_ff;
            pos_wa = oq_a; pos_wd_max = k_ff; pos_wd_min = k_ff;
         end
         CMD_SU_RD_ORD: begin
            ord_ra = k_ff; ord_rb = par;
         end
         CMD_SU_RD_KP, CMD_SD_RD_KP: begin
            sa_in = oq_a; sb_in = oq_b; kp_ra = oq_a; kp_rb = oq_b;
            ord_ra = k_ff;
         end
         CMD_SU_SWAP1: begin
            ord_we_max = !hsel_ff; ord_we_min = hsel_ff;
            ord_wa_max = k_ff; ord_wa_min = k_ff; ord_wd = sb_ff;
            pos_we_max = !hsel_ff; pos_we_min = hsel_ff;
            pos_wa = sb_ff; pos_wd_max = k_ff; pos_wd_min = k_ff;
         end
         CMD_SU_SWAP2: begin
            ord_we_max = !hsel_ff; ord_we_min = hsel_ff;
            ord_wa_max = par; ord_wa_min = par; ord_wd = sa_ff;
            pos_we_max = !hsel_ff; pos_we_min = hsel_ff;
            pos_wa = sa_ff; pos_wd_max = par; pos_wd_min = par;
            k_in = par;
         end
         CMD_SD_RD_ORD: begin
            ord_ra = IW'(cpos); ord_rb = IW'(cpos1);
         end
         CMD_SD_PICK: begin
            if (pick_b) begin
               c_in = IW'(cpos1); sa_in = sb_ff; ck_in = key_qb_ff; cp_in = prio_qb_ff;
            end else begin
               c_in = IW'(cpos); ck_in = key_qa_ff; cp_in = prio_qa_ff;
            end
            // The order read issued last cycle returns the slot at position k.
            sb_in = oq_a; kp_ra = oq_a;
         end
         CMD_SD_SWAP1: begin
            ord_we_max = !hsel_ff; ord_we_min = hsel_ff;
            ord_wa_max = c_ff; ord_wa_min = c_ff; ord_wd = sb_ff;
            pos_we_max = !hsel_ff; pos_we_min = hsel_ff;
            pos_wa = sb_ff; pos_wd_max = c_ff; pos_wd_min = c_ff;
         end
         CMD_SD_SWAP2: begin
            ord_we_max = !hsel_ff; ord_we_min = hsel_ff;
            ord_wa_max = k_ff; ord_wa_min = k_ff; ord_wd = sa_ff;
            pos_we_max = !hsel_ff; pos_we_min = hsel_ff;
            pos_wa = sa_ff; pos_wd_max = k_ff; pos_wd_min = k_ff;
            k_in = c_ff;
         end
         CMD_NEXT_HEAP: hsel_in = 1'b1;
         CMD_DEC: cnt_in = cnt_m1;
         CMD_CP_RD: begin
            kp_ra = IW'(cnt_ff); pos_ra = IW'(cnt_ff);
         end
         CMD_CP_WR: begin
            // Move the top slot down into the freed one and repoint both heaps.
            key_we = 1'b1; prio_we = 1'b1; kp_wa = slot_ff;
            key_wd = key_qa_ff; prio_wd = prio_qa_ff;
            pos_we_max = 1'b1; pos_we_min = 1'b1; pos_wa = slot_ff;
            pos_wd_max = pmax_q_ff; pos_wd_min = pmin_q_ff;
            ord_we_max = 1'b1; ord_we_min = 1'b1;
            ord_wa_max = pmax_q_ff; ord_wa_min = pmin_q_ff; ord_wd = slot_ff;
         end
         CMD_PUBLISH: begin
            ost_in = st_ff; oid_in = rid_ff; oval_in = rval_ff;
            ocnt_in = CNT_O_W'(cnt_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (key_we) key_mem[kp_wa] <= key_wd;
      if (prio_we) prio_mem[kp_wa] <= prio_wd;
      key_qa_ff  <= key_mem[kp_ra];
      key_qb_ff  <= key_mem[kp_rb];
      prio_qa_ff <= prio_mem[kp_ra];
      prio_qb_ff <= prio_mem[kp_rb];
   end

   always_ff @(posedge clock) begin
      if (ord_we_max) ord_max_mem[ord_wa_max] <= ord_wd;
      if (ord_we_min) ord_min_mem[ord_wa_min] <= ord_wd;
      omax_qa_ff <= ord_max_mem[ord_ra];
      omax_qb_ff <= ord_max_mem[ord_rb];
      omin_qa_ff <= ord_min_mem[ord_ra];
      omin_qb_ff <= ord_min_mem[ord_rb];
   end

   always_ff @(posedge clock) begin
      if (pos_we_max) pos_max_mem[pos_wa] <= pos_wd_max;
      if (pos_we_min) pos_min_mem[pos_wa] <= pos_wd_min;
      pmax_q_ff <= pos_max_mem[pos_ra];
      pmin_q_ff <= pos_min_mem[pos_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;     id_ff <= id_in;     val_ff <= val_in;
      rid_ff <= rid_in;   rval_ff <= rval_in; ck_ff <= ck_in;   cp_ff <= cp_in;
      st_ff <= st_in;     idx_ff <= idx_in;   nlim_ff <= nlim_in;
      slot_ff <= slot_in; k_ff <= k_in;       c_ff <= c_in;
      sa_ff <= sa_in;     sb_ff <= sb_in;     hsel_ff <= hsel_in;
      ost_ff <= ost_in;   oid_ff <= oid_in;   oval_ff <= oval_in; ocnt_ff <= ocnt_in;
   end

   assign out_status = ost_ff;
   assign out_id     = oid_ff;
   assign out_value  = oval_ff;
   assign out_count  = ocnt_ff;

endmodule

// ===== rtl/core/depq_ctrl.sv =====
// ----------------------------------------------------------------------------
// depq_ctrl
// Sequencer for the queue: id search, insert, removal and the sift passes
// over both heaps, plus the response handshake.
// ----------------------------------------------------------------------------
`include "double_ended_priority_queue_unit_macros.svh"

module depq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output depq_pkg::dp_ctl_type  ctl,
   input  depq_pkg::dp_stat_type stat
);
   import depq_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_CK, S_POP_SLOT, S_ENT_TAKE,
      S_POS_RD, S_TAKE_POS, S_MOVE_LAST, S_SU_CHK, S_SU_KP, S_SU_CMP,
      S_SU_SWAP2, S_SU_END, S_SD_CHK, S_SD_KP, S_SD_PICK, S_SD_CMP,
      S_SD_SWAP2, S_HEAP_END, S_CP_CHK, S_CP_WR, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      ctl.op   = CMD_NONE;
      ctl.code = ST_OK;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ctl.op = CMD_LOAD; state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.op)
               OP_INSERT, OP_DELETE, OP_CHANGE: state_in = S_SCAN_RD;
               OP_POP_MAX, OP_POP_MIN: begin
                  if (stat.empty) begin
                     ctl.op = CMD_FAIL; ctl.code = ST_EMPTY; state_in = S_DONE;
                  end else begin
                     ctl.op = CMD_POP_RD; state_in = S_POP_SLOT;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_SCAN_RD: begin
            if (stat.scan_end) begin
               if (stat.op != OP_INSERT) begin
                  ctl.op = CMD_FAIL; ctl.code = ST_NOT_FOUND; state_in = S_DONE;
               end else if (stat.full) begin
                  ctl.op = CMD_FAIL; ctl.code = ST_FULL; state_in = S_DONE;
               end else begin
                  ctl.op = CMD_INS_WRITE; state_in = S_SU_CHK;
               end
            end else begin
               ctl.op = CMD_SCAN_RD; state_in = S_SCAN_CK;
            end
         end
         S_SCAN_CK: begin
            if (!stat.key_hit) begin
               ctl.op = CMD_SCAN_NEXT; state_in = S_SCAN_RD;
            end else if (stat.op == OP_INSERT) begin
               ctl.op = CMD_FAIL; ctl.code = ST_DUPLICATE; state_in = S_DONE;
            end else begin
               ctl.op = CMD_SCAN_HIT; state_in = S_POS_RD;
            end
         end
         S_POP_SLOT: begin
            ctl.op = CMD_POP_SLOT; state_in = S_ENT_TAKE;
         end
         S_ENT_TAKE: begin
            ctl.op = CMD_ENT_TAKE; state_in = S_POS_RD;
         end
         S_POS_RD: begin
            ctl.op = CMD_POS_RD; state_in = S_TAKE_POS;
         end
         S_TAKE_POS: begin
            ctl.op = CMD_TAKE_POS;
            if (stat.op == OP_CHANGE) begin
               state_in = S_SU_CHK;
            end else if (stat.pos_last) begin
               // Removing the last heap position needs no repair.
               state_in = S_HEAP_END;
            end else begin
               state_in = S_MOVE_LAST;
            end
         end
         S_MOVE_LAST: begin
            ctl.op = CMD_MOVE_LAST; state_in = S_SU_CHK;
         end
         S_SU_CHK: begin
            if (stat.k_zero) begin
               state_in = S_SU_END;
            end else begin
               ctl.op = CMD_SU_RD_ORD; state_in = S_SU_KP;
            end
         end
         S_SU_KP: begin
            ctl.op = CMD_SU_RD_KP; state_in = S_SU_CMP;
         end
         S_SU_CMP: begin
            if (stat.first_ab) begin
               ctl.op = CMD_SU_SWAP1; state_in = S_SU_SWAP2;
            end else begin
               state_in = S_SU_END;
            end
         end
         S_SU_SWAP2: begin
            ctl.op = CMD_SU_SWAP2; state_in = S_SU_CHK;
         end
         S_SU_END: begin
            if (stat.op != OP_INSERT) begin
               state_in = S_SD_CHK;
            end else if (!stat.heap_min) begin
               ctl.op = CMD_INS_MIN; state_in = S_SU_CHK;
            end else begin
               ctl.op = CMD_INC; state_in = S_DONE;
            end
         end
         S_SD_CHK: begin
            if (stat.sd_end) begin
               state_in = S_HEAP_END;
            end else begin
               ctl.op = CMD_SD_RD_ORD; state_in = S_SD_KP;
            end
         end
         S_SD_KP: begin
            ctl.op = CMD_SD_RD_KP; state_in = S_SD_PICK;
         end
         S_SD_PICK: begin
            ctl.op = CMD_SD_PICK; state_in = S_SD_CMP;
         end
         S_SD_CMP: begin
            if (stat.first_ca) begin
               ctl.op = CMD_SD_SWAP1; state_in = S_SD_SWAP2;
            end else begin
               state_in = S_HEAP_END;
            end
         end
         S_SD_SWAP2: begin
            ctl.op = CMD_SD_SWAP2; state_in = S_SD_CHK;
         end
         S_HEAP_END: begin
            if (!stat.heap_min) begin
               ctl.op = CMD_NEXT_HEAP; state_in = S_POS_RD;
            end else if (stat.op == OP_CHANGE) begin
               state_in = S_DONE;
            end else begin
               ctl.op = CMD_DEC; state_in = S_CP_CHK;
            end
         end
         S_CP_CHK: begin
            if (stat.slot_last) begin
               state_in = S_DONE;
            end else begin
               ctl.op = CMD_CP_RD; state_in = S_CP_WR;
            end
         end
         S_CP_WR: begin
            ctl.op = CMD_CP_WR; state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               ctl.op = CMD_PUBLISH; rsp_valid_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `DEPQ_ASSERT_IMP(a_publish_free, clock, reset, (ctl.op == CMD_PUBLISH), (!rsp_valid_ff || rsp_tready), "result overwritten before transfer")
   `DEPQ_ASSERT_NXT(a_accept_starts, clock, reset, (req_tvalid && req_tready), (state_ff == S_DISPATCH), "accepted request not dispatched")
   `DEPQ_ASSERT_IMP(a_valid_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_DONE), "result raised outside completion")

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Double-ended priority queue unit testbench
// Drives insert, pop, delete, change and unused-code requests with random pacing and
// back-pressure, and checks every response against a behavioral model.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import depq_pkg::*;

   localparam int CAP       = 1024;
   localparam int WDOG_MAX  = 200000;
   localparam int N_RANDOM  = 200;
   localparam logic [OP_W-1:0] OP_UNUSED5 = 3'd5;
   localparam logic [OP_W-1:0] OP_UNUSED7 = 3'd7;

   typedef struct packed {
      logic [ST_W-1:0]    status;
      logic [ID_W-1:0]    id;
      logic [VAL_W-1:0]   value;
      logic [CNT_O_W-1:0] count;
   } answer_type;

   typedef struct {
      logic [OP_W-1:0]  op;
      logic [ID_W-1:0]  id;
      logic [VAL_W-1:0] value;
      bit               typed;
      answer_type       answer;
   } request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   double_ended_priority_queue_unit #(.CAPACITY(CAP)) dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Model state: entries kept as an unordered list; roots found by scan.
   logic [ID_W-1:0]  held_id[$];
   logic [VAL_W-1:0] held_val[$];
   answer_type       pending[$];
   int               mismatches = 0;
   int               responses = 0;
   int               sent = 0;
   int               n_full = 0, n_dup = 0, n_empty = 0, n_miss = 0;
   int               idle_cycles = 0;

   function automatic bit ahead(bit min_mode, int a, int b);
      logic signed [VAL_W-1:0] va, vb;
      va = held_val[a];
      vb = held_val[b];
      if (!min_mode) return va > vb || (va == vb && held_id[a] < held_id[b]);
      return va < vb || (va == vb && held_id[a] > held_id[b]);
   endfunction

   function automatic int locate(logic [ID_W-1:0] id);
      foreach (held_id[i]) if (held_id[i] == id) return i;
      return -1;
   endfunction

   function automatic answer_type queue_step(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                             logic [VAL_W-1:0] value);
      answer_type r;
      int         k;
      r = '0;
      case (op)
         OP_INSERT: begin
            if (locate(id) >= 0) r.status = ST_DUPLICATE;
            else if (held_id.size() >= CAP) r.status = ST_FULL;
            else begin
               held_id.push_back(id);
               held_val.push_back(value);
               r.id = id;
               r.value = value;
            end
         end
         OP_POP_MAX, OP_POP_MIN: begin
            if (held_id.size() == 0) r.status = ST_EMPTY;
            else begin
               k = 0;
               foreach (held_id[i]) if (ahead(op == OP_POP_MIN, i, k)) k = i;
               r.id = held_id[k];
               r.value = held_val[k];
               held_id.delete(k);
               held_val.delete(k);
            end
         end
         OP_DELETE, OP_CHANGE: begin
            k = locate(id);
            if (k < 0) r.status = ST_NOT_FOUND;
            else begin
               r.id = held_id[k];
               r.value = held_val[k];
               if (op == OP_DELETE) begin
                  held_id.delete(k);
                  held_val.delete(k);
               end else begin
                  held_val[k] = value;
               end
            end
         end
         default: ;
      endcase
      r.count = CNT_O_W'(held_id.size());
      return r;
   endfunction

   // Presents one request from the next falling edge and returns at the
   // rising edge of its transfer; tvalid stays up for a following request.
   task automatic send(request_type rq);
      answer_type predicted;
      @(negedge clock);
      req_tdata <= {1'b0, rq.value, rq.id};
      req_tuser <= rq.op;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      predicted = queue_step(rq.op, rq.id, rq.value);
      if (rq.typed && predicted != rq.answer) begin
         mismatches++;
         if (mismatches <= 10)
            $display("table row disagrees with model: row %h model %h", rq.answer, predicted);
      end
      case (predicted.status)
         ST_FULL: n_full++;
         ST_DUPLICATE: n_dup++;
         ST_EMPTY: n_empty++;
         ST_NOT_FOUND: n_miss++;
         default: ;
      endcase
      pending.push_back(predicted);
   endtask

   task automatic idle_gap(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   task automatic drain();
      idle_gap(1);
      while (pending.size() != 0) @(negedge clock);
   endtask

   // Response checker and back-pressure pattern.
   int stall_phase = 0;
   always @(negedge clock) begin
      stall_phase <= stall_phase + 1;
      rsp_tready <= (stall_phase % 97 < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      answer_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[30:0], rsp_tdata[62:31], rsp_tdata[73:63]};
         responses++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            want = pending.pop_front();
            if (got != want || rsp_tdata[79:74] != '0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: status %0d/%0d id %h/%h value %h/%h count %0d/%0d",
                           want.status, got.status, want.id, got.id,
                           want.value, got.value, want.count, got.count);
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else if (!reset) idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("watchdog expired");
         $display("simulation failed");
         $finish;
      end
   end

   function automatic request_type row(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                       logic [VAL_W-1:0] value, bit typed = 0,
                                       logic [ST_W-1:0] st = ST_OK,
                                       logic [ID_W-1:0] oid = '0,
                                       logic [VAL_W-1:0] oval = '0, int cnt = 0);
      request_type r;
      r.op = op; r.id = id; r.value = value; r.typed = typed;
      r.answer = {st, oid, oval, CNT_O_W'(cnt)};
      return r;
   endfunction

   function automatic logic [ID_W-1:0] pick_id(int pool);
      if ($urandom_range(0, 9) == 0) return ID_W'($urandom());
      if (held_id.size() > 0 && $urandom_range(0, 2) == 0)
         return held_id[$urandom_range(0, held_id.size() - 1)];
      return ID_W'($urandom_range(0, pool));
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 3))
         0: return VAL_W'($urandom_range(0, 7) - 4);
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return $urandom();
      endcase
   endfunction

   request_type     directed[$];
   request_type     rq;
   int              burst, fill_target;
   logic [ID_W-1:0] fill_id;

   initial begin
      directed = '{
         row(OP_POP_MAX, 0, 0, 1, ST_EMPTY),
         row(OP_POP_MIN, 0, 0, 1, ST_EMPTY),
         row(OP_DELETE, 5, 0, 1, ST_NOT_FOUND),
         row(OP_CHANGE, 5, 9, 1, ST_NOT_FOUND),
         row(OP_UNUSED5, 3, 3, 1, ST_OK),
         row(OP_INSERT, 31'h7fffffff, 32'h7fffffff, 1, ST_OK, 31'h7fffffff, 32'h7fffffff, 1),
         row(OP_INSERT, 0, 32'h80000000, 1, ST_OK, 0, 32'h80000000, 2),
         row(OP_INSERT, 0, 5, 1, ST_DUPLICATE, 0, 0, 2),
         row(OP_INSERT, 10, 32'h7fffffff, 1, ST_OK, 10, 32'h7fffffff, 3),
         row(OP_INSERT, 20, 32'h80000000, 1, ST_OK, 20, 32'h80000000, 4),
         row(OP_INSERT, 30, 32'h55555555, 0),
         row(OP_INSERT, 40, 32'haaaaaaaa, 0),
         row(OP_UNUSED7, 31'h2aaaaaaa, 32'hffffffff, 1, ST_OK, 0, 0, 6),
         row(OP_POP_MAX, 0, 0, 1, ST_OK, 10, 32'h7fffffff, 5),
         row(OP_POP_MIN, 0, 0, 1, ST_OK, 20, 32'h80000000, 4),
         row(OP_CHANGE, 30, 32'h80000000, 0),
         row(OP_CHANGE, 40, 32'h7fffffff, 0),
         row(OP_DELETE, 31'h7fffffff, 0, 0),
         row(OP_POP_MAX, 0, 0, 0),
         row(OP_POP_MIN, 0, 0, 0),
         row(OP_DELETE, 0, 0, 0),
         row(OP_POP_MIN, 0, 0, 1, ST_EMPTY)
      };
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_gap(3);

      foreach (directed[i]) send(directed[i]);
      drain();

      // Random part: mostly small queues keep the id search short.
      for (int n = 0; n < N_RANDOM; ) begin
         burst = $urandom_range(1, 16);
         fill_target = $urandom_range(0, 1) ? 8 : 40;
         for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
            rq.typed = 0;
            case ($urandom_range(0, 19))
               0,1,2,3,4,5: rq.op = (held_id.size() < fill_target) ? OP_INSERT : OP_POP_MAX;
               6,7,8: rq.op = OP_POP_MAX;
               9,10,11: rq.op = OP_POP_MIN;
               12,13,14: rq.op = OP_DELETE;
               15,16,17,18: rq.op = OP_CHANGE;
               default: rq.op = OP_W'($urandom_range(0, 7));
            endcase
            rq.id = pick_id(63);
            rq.value = pick_value();
            send(rq);
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(0, 30));
         if (n % 64 < 16) drain();
      end

      // Fill to capacity once to reach the full case, then pop a few.
      drain();
      fill_id = 31'd1000;
      while (held_id.size() < CAP) begin
         send(row(OP_INSERT, fill_id, $urandom()));
         fill_id++;
      end
      send(row(OP_INSERT, 31'h7ffffff0, 32'd1));
      send(row(OP_INSERT, held_id[0], 32'd1));
      for (int i = 0; i < 24; i++)
         send(row($urandom_range(0, 1) ? OP_POP_MAX : OP_POP_MIN, 0, 0));

      drain();
      idle_gap(20);
      $display("%0d requests sent, %0d responses checked, queue filled to capacity once",
               sent, responses);
      $display("error cases seen: full %0d, duplicate %0d, empty %0d, unknown id %0d",
               n_full, n_dup, n_empty, n_miss);
      if (mismatches == 0 && pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("simulation failed");
      end
      $finish;
   end

endmodule
